FILE: rtl/core/tkrm_pkg.sv
package tkrm_pkg;

    // table and queue sizes
    localparam int KEYS        = 16;
    localparam int QUEUE_DEPTH = 16;

    localparam int KEY_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam int BOUND_WORDS = 8;
    localparam int NOW_W       = 48;
    localparam int DELAY_W     = 32;

    // table word numbers beyond the bounds
    localparam logic [3:0] WORD_COUNT = 4'd8;
    localparam logic [3:0] WORD_CODE  = 4'd9;

    // request kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TOUCH = 2'd1;
    localparam logic [1:0] KIND_POP   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] first_x;
        logic [15:0] first_y;
        logic        first_tip;
        logic [15:0] second_x;
        logic [15:0] second_y;
        logic        second_tip;
        logic [3:0]  contacts;
        logic [47:0] now;
        logic [7:0]  table_address;
        logic [15:0] load_value;
    } tkrm_req_t;

    typedef struct packed {
        logic [15:0] popped_code;
        logic        popped_valid;
        logic        queued;
        logic        matched;
        logic [3:0]  matched_key;
        logic [4:0]  pending;
    } tkrm_res_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic load;
        logic pop;
        logic clear;
        logic scan_start;
        logic scan_next;
        logic hit_update;
        logic finish;
    } tkrm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       hit;
        logic       last_key;
    } tkrm_sts_t;

endpackage

FILE: rtl/core/tkrm_ram.sv
module tkrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/tkrm_ctrl.sv
module tkrm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tkrm_pkg::tkrm_sts_t sts,
    output tkrm_pkg::tkrm_cmd_t cmd
);
    import tkrm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_READ     = 3'd2;
    localparam logic [2:0] S_TEST     = 3'd3;
    localparam logic [2:0] S_FINISH   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.kind)
                    KIND_LOAD:
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_FINISH;
                    end
                    KIND_TOUCH:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_READ;
                    end
                    KIND_POP:
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_FINISH;
                    end
                endcase
            end
            // table ram read in flight for the current key
            S_READ:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (sts.hit)
                begin
                    cmd.hit_update = 1'b1;
                    state_next     = S_FINISH;
                end
                else if (sts.last_key)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tkrm_datapath.sv
module tkrm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  tkrm_pkg::tkrm_req_t request,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  tkrm_pkg::tkrm_cmd_t cmd,
    output tkrm_pkg::tkrm_sts_t sts,
    output tkrm_pkg::tkrm_res_t result,
    output logic               done
);
    import tkrm_pkg::*;

    tkrm_req_t req_reg;
    logic [DELAY_W-1:0] delay_reg;

    logic [KEY_W-1:0] key_cnt_reg;

    // bound words live in rams, one per word; valid bits give the zero reset
    logic [BOUND_WORDS-1:0] bound_valid_reg [KEYS];
    logic [15:0]            bound_rdata [BOUND_WORDS];
    logic [15:0]            bound [BOUND_WORDS];

    logic [1:0]  need_reg [KEYS];
    logic [15:0] code_reg [KEYS];

    logic [NOW_W-1:0] stamp_reg [KEYS];
    logic [KEYS-1:0]  stamp_set_reg;

    logic [15:0]       queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg;
    logic [FILL_W-1:0] fill_reg;

    logic [15:0] pcode_reg;
    logic        pvalid_reg;
    logic        queued_reg;
    logic        matched_reg;
    logic [3:0]  mkey_reg;

    tkrm_res_t result_reg;
    logic      done_reg;

    // load address decode
    logic [3:0]       ld_word;
    logic             ld_key_ok;
    logic [KEY_W-1:0] ld_key;

    assign ld_word   = req_reg.table_address[3:0];
    assign ld_key_ok = int'(req_reg.table_address[7:4]) < KEYS;
    assign ld_key    = KEY_W'(req_reg.table_address[7:4]);

    for (genvar w = 0; w < BOUND_WORDS; w++)
    begin : g_bound
        tkrm_ram #(
            .WIDTH(16),
            .DEPTH(KEYS)
        ) u_bound_ram (
            .clk  (clk),
            .we   (cmd.load && ld_key_ok && (ld_word == 4'(w))),
            .waddr(ld_key),
            .wdata(req_reg.load_value),
            .raddr(key_cnt_reg),
            .rdata(bound_rdata[w])
        );
        assign bound[w] = bound_valid_reg[key_cnt_reg][w] ? bound_rdata[w] : 16'd0;
    end

    // region test for the key under scan
    logic r0_p0;
    logic r1_p1;
    logic r0_p1;
    logic r1_p0;
    logic hit;

    assign r0_p0 = (req_reg.first_x > bound[0]) && (req_reg.first_x < bound[1]) &&
                   (req_reg.first_y > bound[2]) && (req_reg.first_y < bound[3]);
    assign r1_p1 = (req_reg.second_x > bound[4]) && (req_reg.second_x < bound[5]) &&
                   (req_reg.second_y > bound[6]) && (req_reg.second_y < bound[7]);
    assign r0_p1 = (req_reg.second_x > bound[0]) && (req_reg.second_x < bound[1]) &&
                   (req_reg.second_y > bound[2]) && (req_reg.second_y < bound[3]);
    assign r1_p0 = (req_reg.first_x > bound[4]) && (req_reg.first_x < bound[5]) &&
                   (req_reg.first_y > bound[6]) && (req_reg.first_y < bound[7]);

    always_comb
    begin
        hit = 1'b0;
        if ({2'b00, need_reg[key_cnt_reg]} == req_reg.contacts)
        begin
            if (req_reg.contacts == 4'd1)
            begin
                hit = req_reg.first_tip && r0_p0;
            end
            else if (req_reg.contacts == 4'd2)
            begin
                hit = req_reg.first_tip && req_reg.second_tip &&
                      ((r0_p0 && r1_p1) || (r0_p1 && r1_p0));
            end
        end
    end

    assign sts.kind     = req_reg.kind;
    assign sts.hit      = hit;
    assign sts.last_key = (key_cnt_reg == KEY_W'(KEYS - 1));

    // repeat check, sum kept at 49 bits so it never wraps
    logic [NOW_W-1:0] stamp_eff;
    logic [NOW_W:0]   stamp_limit;
    logic             fire;

    assign stamp_eff   = stamp_set_reg[key_cnt_reg] ? stamp_reg[key_cnt_reg] : '0;
    assign stamp_limit = {1'b0, stamp_eff} + (NOW_W + 1)'(delay_reg);
    assign fire        = (stamp_eff == '0) || ({1'b0, req_reg.now} > stamp_limit);

    // queue pointers
    logic [QPTR_W:0]   tail_sum;
    logic [QPTR_W-1:0] tail;
    logic [QPTR_W-1:0] head_inc;

    assign tail_sum = (QPTR_W + 1)'(head_reg) + (QPTR_W + 1)'(fill_reg);
    assign tail     = (int'(tail_sum) >= QUEUE_DEPTH) ?
                      QPTR_W'(int'(tail_sum) - QUEUE_DEPTH) : QPTR_W'(tail_sum);
    assign head_inc = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= request;
        end
        if (cmd.hit_update && fire)
        begin
            stamp_reg[key_cnt_reg] <= req_reg.now;
            if (int'(fill_reg) < QUEUE_DEPTH)
            begin
                queue_reg[tail] <= code_reg[key_cnt_reg];
            end
        end
        if (cmd.finish)
        begin
            result_reg.popped_code  <= pcode_reg;
            result_reg.popped_valid <= pvalid_reg;
            result_reg.queued       <= queued_reg;
            result_reg.matched      <= matched_reg;
            result_reg.matched_key  <= mkey_reg;
            result_reg.pending      <= 5'(fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= '0;
            key_cnt_reg   <= '0;
            stamp_set_reg <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            pcode_reg     <= '0;
            pvalid_reg    <= 1'b0;
            queued_reg    <= 1'b0;
            matched_reg   <= 1'b0;
            mkey_reg      <= '0;
            done_reg      <= 1'b0;
            for (int k = 0; k < KEYS; k++)
            begin
                bound_valid_reg[k] <= '0;
                need_reg[k]        <= '0;
                code_reg[k]        <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_we)
            begin
                delay_reg <= cfg_data;
            end
            if (cmd.latch)
            begin
                pcode_reg   <= '0;
                pvalid_reg  <= 1'b0;
                queued_reg  <= 1'b0;
                matched_reg <= 1'b0;
                mkey_reg    <= '0;
            end
            if (cmd.load && ld_key_ok)
            begin
                if (ld_word < 4'(BOUND_WORDS))
                begin
                    bound_valid_reg[ld_key][ld_word[2:0]] <= 1'b1;
                end
                else if (ld_word == WORD_COUNT)
                begin
                    need_reg[ld_key] <= req_reg.load_value[1:0];
                end
                else if (ld_word == WORD_CODE)
                begin
                    code_reg[ld_key] <= req_reg.load_value;
                end
            end
            if (cmd.scan_start)
            begin
                key_cnt_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                key_cnt_reg <= key_cnt_reg + 1'b1;
            end
            if (cmd.hit_update)
            begin
                matched_reg <= 1'b1;
                mkey_reg    <= 4'(key_cnt_reg);
                if (fire)
                begin
                    stamp_set_reg[key_cnt_reg] <= 1'b1;
                    if (int'(fill_reg) < QUEUE_DEPTH)
                    begin
                        fill_reg   <= fill_reg + 1'b1;
                        queued_reg <= 1'b1;
                    end
                end
            end
            if (cmd.pop && (fill_reg != '0))
            begin
                pcode_reg  <= queue_reg[head_reg];
                pvalid_reg <= 1'b1;
                head_reg   <= head_inc;
                fill_reg   <= fill_reg - 1'b1;
            end
            if (cmd.clear)
            begin
                fill_reg      <= '0;
                head_reg      <= '0;
                stamp_set_reg <= '0;
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

FILE: rtl/core/touch_key_region_matcher_unit.sv
// done rises after the finish state; load, pop and clear go from dispatch straight
// to finish, while a touch report first scans the keys, each key needing one table
// ram read state and one test state
// busy drops with done, so no new request is taken until the previous one finishes;
// the receiver cannot stall results
// reset clears the key table, stamps, queue fill and repeat delay
module touch_key_region_matcher_unit (
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               start,
    output logic               busy,
    input  tkrm_pkg::tkrm_req_t request,
    // repeat delay register
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    // result side
    output tkrm_pkg::tkrm_res_t result,
    output logic               done
);
    import tkrm_pkg::*;

    // command and status between sequencer and datapath
    tkrm_cmd_t cmd;
    tkrm_sts_t sts;

    // sequencer: dispatch by kind, walk keys for touch reports
    tkrm_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .sts  (sts),
        .cmd  (cmd)
    );

    // datapath: key table rams, region test, stamps, code queue, result register
    tkrm_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

endmodule

FILE: sim/touch_key_region_matcher_unit_test.sv
module touch_key_region_matcher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tkrm_pkg::*;

    // table word layout of one key
    localparam int WORDS_PER_KEY = 16;
    // first word number past the code word, loads there are dropped
    localparam int WORD_SPARE = WORD_CODE + 1;

    // clock, reset and block ports, all known from time zero
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    tkrm_req_t          request = '0;
    logic               cfg_we = 1'b0;
    logic [DELAY_W-1:0] cfg_data = '0;
    tkrm_res_t          result;
    logic               done;

    // shadow copy of the key table, press stamps, code queue and delay register
    logic [15:0]        key_box [KEYS][BOUND_WORDS];
    logic [1:0]         key_need [KEYS];
    logic [15:0]        key_sym [KEYS];
    logic [NOW_W-1:0]   key_stamp [KEYS];
    logic [15:0]        code_fifo [$];
    logic [DELAY_W-1:0] delay_shadow = '0;

    // results predicted for accepted requests, oldest first
    tkrm_res_t          awaited_results [$];
    tkrm_res_t          oldest_result;

    int                 fail_count = 0;
    // sender burst shaping: requests left in this burst, longest gap
    int                 burst_left = 0;
    int                 gap_max = 0;
    // running touch timer
    logic [NOW_W-1:0]   tick_now = '0;

    touch_key_region_matcher_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .result   (result),
        .done     (done)
    );

    always #6 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // key matching predictor
    // ---------------------------------------------------------------

    // strict containment in one rectangle of a key
    function automatic bit in_box(int k, int rect, logic [15:0] x, logic [15:0] y);
        int b;
        b = rect * 4;
        return x > key_box[k][b] && x < key_box[k][b + 1] &&
               y > key_box[k][b + 2] && y < key_box[k][b + 3];
    endfunction

    // one key against the touching contacts of a report
    function automatic bit key_hit(int k, tkrm_req_t r);
        if (r.contacts != {2'b00, key_need[k]})
            return 1'b0;
        // single contact: only the first one and rectangle 0 count
        if (r.contacts == 4'd1)
            return r.first_tip && in_box(k, 0, r.first_x, r.first_y);
        // two contacts: both must touch, either one may sit in either rectangle
        if (r.contacts == 4'd2)
            return r.first_tip && r.second_tip &&
                   ((in_box(k, 0, r.first_x, r.first_y) &&
                     in_box(k, 1, r.second_x, r.second_y)) ||
                    (in_box(k, 0, r.second_x, r.second_y) &&
                     in_box(k, 1, r.first_x, r.first_y)));
        return 1'b0;
    endfunction

    // updates the shadow state for one request and returns its result
    function automatic tkrm_res_t apply_key_request(tkrm_req_t r);
        tkrm_res_t  res;
        int         key;
        int         word;
        int         k;
        bit         found;
        logic [48:0] release_at;
        res   = '0;
        found = 1'b0;
        case (r.kind)
            KIND_LOAD:
            begin
                key  = int'(r.table_address) / WORDS_PER_KEY;
                word = int'(r.table_address) % WORDS_PER_KEY;
                // words past the code word and keys past the table are dropped
                if (key < KEYS)
                begin
                    if (word < BOUND_WORDS)
                        key_box[key][word] = r.load_value;
                    else if (word == WORD_COUNT)
                        key_need[key] = r.load_value[1:0];
                    else if (word == WORD_CODE)
                        key_sym[key] = r.load_value;
                end
            end
            KIND_TOUCH:
            begin
                // first key in index order wins
                for (k = 0; k < KEYS && !found; k++)
                begin
                    if (key_hit(k, r))
                    begin
                        found           = 1'b1;
                        res.matched     = 1'b1;
                        res.matched_key = k[3:0];
                        // stamp plus delay formed one bit wider, no wrap
                        release_at = {1'b0, key_stamp[k]} + {17'd0, delay_shadow};
                        // a zero stamp reads as never pressed
                        if (key_stamp[k] == '0 || {1'b0, r.now} > release_at)
                        begin
                            key_stamp[k] = r.now;
                            // full queue drops the code, stamp still moves
                            if (code_fifo.size() < QUEUE_DEPTH)
                            begin
                                code_fifo.push_back(key_sym[k]);
                                res.queued = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_POP:
            begin
                // empty queue gives code 0 and no valid
                if (code_fifo.size() != 0)
                begin
                    res.popped_code  = code_fifo.pop_front();
                    res.popped_valid = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                // table and delay register are kept
                code_fifo.delete();
                foreach (key_stamp[i])
                    key_stamp[i] = '0;
            end
        endcase
        res.pending = 5'(code_fifo.size());
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checking, every done strobe against the oldest prediction
    // ---------------------------------------------------------------

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with no request waiting, expected none actual %p",
                         $time, result);
                fail_count++;
            end
            else
            begin
                oldest_result = awaited_results.pop_front();
                check_field("popped_code", oldest_result.popped_code, result.popped_code);
                check_field("popped_valid", 16'(oldest_result.popped_valid),
                            16'(result.popped_valid));
                check_field("queued", 16'(oldest_result.queued), 16'(result.queued));
                check_field("matched", 16'(oldest_result.matched), 16'(result.matched));
                check_field("matched_key", 16'(oldest_result.matched_key),
                            16'(result.matched_key));
                check_field("pending", 16'(oldest_result.pending), 16'(result.pending));
            end
        end
    end

    // ---------------------------------------------------------------
    // request driving
    // ---------------------------------------------------------------

    // issues one request; start stays high on return so that a request sent
    // right after keeps it up, any pause lowers it first
    task automatic send_request(input tkrm_req_t req);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        request <= req;
        start   <= 1'b1;
        // accepted at the first edge with busy low
        do
            @(posedge clk);
        while (busy !== 1'b0);
        awaited_results.push_back(apply_key_request(req));
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_for_results();
        start      <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0 || busy !== 1'b0);
    endtask

    // delay register written only with the block idle
    task automatic set_repeat_delay(input logic [DELAY_W-1:0] value);
        wait_for_results();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we       <= 1'b0;
        delay_shadow = value;
    endtask

    // ---------------------------------------------------------------
    // request builders
    // ---------------------------------------------------------------

    // every field random, callers overwrite what matters
    function automatic tkrm_req_t noise_request();
        tkrm_req_t r;
        r.kind          = 2'($urandom_range(0, 3));
        r.first_x       = 16'($urandom);
        r.first_y       = 16'($urandom);
        r.first_tip     = 1'($urandom_range(0, 1));
        r.second_x      = 16'($urandom);
        r.second_y      = 16'($urandom);
        r.second_tip    = 1'($urandom_range(0, 1));
        r.contacts      = 4'($urandom_range(0, 15));
        r.now           = {16'($urandom), 32'($urandom)};
        r.table_address = 8'($urandom);
        r.load_value    = 16'($urandom);
        return r;
    endfunction

    function automatic tkrm_req_t load_request(logic [7:0] addr, logic [15:0] value);
        tkrm_req_t r;
        r               = noise_request();
        r.kind          = KIND_LOAD;
        r.table_address = addr;
        r.load_value    = value;
        return r;
    endfunction

    function automatic tkrm_req_t op_request(logic [1:0] op);
        tkrm_req_t r;
        r      = noise_request();
        r.kind = op;
        return r;
    endfunction

    function automatic tkrm_req_t touch_request(logic [3:0] cnt,
                                                logic [15:0] fx, logic [15:0] fy, logic ft,
                                                logic [15:0] sx, logic [15:0] sy, logic st,
                                                logic [NOW_W-1:0] at);
        tkrm_req_t r;
        r            = noise_request();
        r.kind       = KIND_TOUCH;
        r.contacts   = cnt;
        r.first_x    = fx;
        r.first_y    = fy;
        r.first_tip  = ft;
        r.second_x   = sx;
        r.second_y   = sy;
        r.second_tip = st;
        r.now        = at;
        return r;
    endfunction

    // timer mostly creeps so repeat suppression bites, sometimes leaps or zeroes
    function automatic logic [NOW_W-1:0] next_tick();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 2)
            return '0;
        if (sel < 72)
            tick_now += 48'($urandom_range(0, 30));
        else if (sel < 92)
            tick_now += 48'($urandom_range(31, 2000));
        else if (sel < 98)
            tick_now += 48'($urandom);
        else
            tick_now = {16'($urandom), 32'($urandom)};
        return tick_now;
    endfunction

    // coordinate inside the open interval, now and then right on an edge
    function automatic logic [15:0] pick_axis(logic [15:0] lo, logic [15:0] hi);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return lo;
        if (sel == 1)
            return hi;
        if (hi > lo + 1)
            return 16'($urandom_range(lo + 1, hi - 1));
        return 16'($urandom);
    endfunction

    function automatic void pick_point(int k, int rect,
                                       output logic [15:0] x, output logic [15:0] y);
        x = pick_axis(key_box[k][rect * 4], key_box[k][rect * 4 + 1]);
        y = pick_axis(key_box[k][rect * 4 + 2], key_box[k][rect * 4 + 3]);
    endfunction

    // loads all ten words of one key; mostly narrow overlapping rectangles so
    // that key order matters, sometimes wide ones reaching the top of the range
    task automatic load_key(int k);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [1:0]  need;
        int          w;
        for (w = 0; w < BOUND_WORDS; w += 2)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                lo = 16'($urandom_range(0, 65000));
                hi = 16'($urandom_range(lo + 2, 65535));
            end
            else
            begin
                lo = 16'($urandom_range(0, 900));
                hi = lo + 16'($urandom_range(2, 300));
            end
            send_request(load_request(8'(k * WORDS_PER_KEY + w), lo));
            send_request(load_request(8'(k * WORDS_PER_KEY + w + 1), hi));
        end
        // count word keeps its low two bits, upper bits are junk
        need = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(1, 2));
        send_request(load_request(8'(k * WORDS_PER_KEY + WORD_COUNT),
                                  {14'($urandom), need}));
        send_request(load_request(8'(k * WORDS_PER_KEY + WORD_CODE), 16'($urandom)));
    endtask

    // touch aimed at one key's rectangles with the contact count it wants
    task automatic touch_known_key();
        tkrm_req_t   r;
        int          k;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] bx;
        logic [15:0] by;
        k          = $urandom_range(0, KEYS - 1);
        r          = noise_request();
        r.kind     = KIND_TOUCH;
        r.contacts = {2'b00, key_need[k]};
        if ($urandom_range(0, 19) == 0)
            r.contacts = 4'($urandom_range(0, 15));
        pick_point(k, 0, ax, ay);
        pick_point(k, 1, bx, by);
        if (r.contacts == 4'd2 && $urandom_range(0, 1) == 1)
        begin
            // contacts reported in the opposite order
            r.first_x  = bx;
            r.first_y  = by;
            r.second_x = ax;
            r.second_y = ay;
        end
        else
        begin
            r.first_x = ax;
            r.first_y = ay;
            if (r.contacts == 4'd2)
            begin
                r.second_x = bx;
                r.second_y = by;
            end
        end
        r.first_tip  = ($urandom_range(0, 9) != 0);
        r.second_tip = ($urandom_range(0, 9) != 0);
        r.now        = next_tick();
        send_request(r);
    endtask

    // mixed traffic, mostly well-aimed touches and pops, some noise
    task automatic run_random_phase(int items);
        tkrm_req_t r;
        int        n;
        int        sel;
        for (n = 0; n < items; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                touch_known_key();
            else if (sel < 72)
                send_request(op_request(KIND_POP));
            else if (sel < 75)
                send_request(op_request(KIND_CLEAR));
            else if (sel < 77)
            begin
                load_key($urandom_range(0, KEYS - 1));
                n += 9;
            end
            else if (sel < 84)
            begin
                // stray table write, spare words included
                r = noise_request();
                r.kind = KIND_LOAD;
                send_request(r);
            end
            else if (sel < 97)
            begin
                r = noise_request();
                if (r.kind == KIND_TOUCH)
                    r.now = next_tick();
                send_request(r);
            end
            else
                wait_for_results();
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // empty table matches nothing, pop on an empty queue
    task automatic test_after_reset();
        gap_max = 0;
        send_request(touch_request(4'd0, 16'd0, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1, '0));
        send_request(op_request(KIND_POP));
    endtask

    // hand-built keys: strict edges, swapped contacts, tip off, odd counts,
    // zero and top timer values, spare word load, pop, clear
    task automatic test_region_matching();
        gap_max = 4;
        // key 0, one contact, box 10..100 on both axes, top code
        send_request(load_request(8'h00, 16'd10));
        send_request(load_request(8'h01, 16'd100));
        send_request(load_request(8'h02, 16'd10));
        send_request(load_request(8'h03, 16'd100));
        send_request(load_request(8'(WORD_COUNT), 16'd1));
        send_request(load_request(8'(WORD_CODE), 16'hFFFF));
        // key 1, two contacts, count word with junk upper bits
        send_request(load_request(8'h10, 16'd200));
        send_request(load_request(8'h11, 16'd300));
        send_request(load_request(8'h12, 16'd200));
        send_request(load_request(8'h13, 16'd300));
        send_request(load_request(8'h14, 16'd400));
        send_request(load_request(8'h15, 16'd500));
        send_request(load_request(8'h16, 16'd400));
        send_request(load_request(8'h17, 16'd500));
        send_request(load_request(8'(WORDS_PER_KEY + WORD_COUNT), 16'hFFFE));
        send_request(load_request(8'(WORDS_PER_KEY + WORD_CODE), 16'h0001));
        // stamp taken at zero, so the second press queues again
        send_request(touch_request(4'd1, 16'd50, 16'd50, 1'b1, 16'd0, 16'd0, 1'b0, '0));
        send_request(touch_request(4'd1, 16'd50, 16'd50, 1'b1, 16'd0, 16'd0, 1'b0, '0));
        // on the edge, not inside
        send_request(touch_request(4'd1, 16'd10, 16'd50, 1'b1, 16'd0, 16'd0, 1'b0, 48'd5));
        // contacts swapped between the rectangles
        send_request(touch_request(4'd2, 16'd450, 16'd450, 1'b1,
                                   16'd250, 16'd250, 1'b1, 48'd7));
        // second contact lifted
        send_request(touch_request(4'd2, 16'd450, 16'd450, 1'b1,
                                   16'd250, 16'd250, 1'b0, 48'd9));
        // count of three never matches
        send_request(touch_request(4'd3, 16'd50, 16'd50, 1'b1,
                                   16'd250, 16'd250, 1'b1, 48'd11));
        send_request(touch_request(4'd1, 16'd50, 16'd50, 1'b1, 16'd0, 16'd0, 1'b1,
                                   {NOW_W{1'b1}}));
        // spare word, dropped
        send_request(load_request(8'(WORD_SPARE + 2), 16'h1234));
        send_request(op_request(KIND_POP));
        send_request(op_request(KIND_CLEAR));
        send_request(op_request(KIND_POP));
    endtask

    task automatic test_table_load();
        int k;
        gap_max = 8;
        for (k = 0; k < KEYS; k++)
            load_key(k);
    endtask

    task automatic test_repeat_delay_zero();
        set_repeat_delay('0);
        gap_max = 12;
        run_random_phase(350);
    endtask

    // longest delay, no sender gaps at all
    task automatic test_repeat_delay_max();
        set_repeat_delay({DELAY_W{1'b1}});
        gap_max = 0;
        run_random_phase(300);
    endtask

    task automatic test_repeat_delay_short();
        set_repeat_delay(DELAY_W'($urandom_range(1, 60)));
        gap_max = 25;
        run_random_phase(350);
    endtask

    task automatic test_repeat_delay_typical();
        set_repeat_delay(DELAY_W'(1000));
        gap_max = 6;
        run_random_phase(300);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        // shadow state matches the block after reset
        foreach (key_box[i, j])
            key_box[i][j] = '0;
        foreach (key_need[i])
        begin
            key_need[i]  = '0;
            key_sym[i]   = '0;
            key_stamp[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_region_matching();
        test_table_load();
        test_repeat_delay_zero();
        test_repeat_delay_max();
        test_repeat_delay_short();
        test_repeat_delay_typical();

        // drain, then allow for the longest scan before judging
        wait_for_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: touch_key_region_matcher_unit.f
rtl/core/tkrm_pkg.sv
rtl/core/tkrm_ram.sv
rtl/core/tkrm_ctrl.sv
rtl/core/tkrm_datapath.sv
rtl/core/touch_key_region_matcher_unit.sv
sim/touch_key_region_matcher_unit_test.sv
